>>> design/sfr_pkg.sv
// sfr_pkg: shared types, constants and codes of the serial frame receiver
// depends on nothing; imported by sfr_ctrl, sfr_readout, serial_frame_receiver and the bench

package sfr_pkg;

   // frame memory geometry
   localparam int BUFFER_DEPTH = 64;
   localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
   localparam int MAX_OUT      = 64;
   localparam int LIMIT_CAP    = (BUFFER_DEPTH < MAX_OUT) ? BUFFER_DEPTH : MAX_OUT;

   // field widths
   localparam int BYTE_W    = 8;
   localparam int LEN_W     = 7;
   localparam int CSR_IDX_W = 2;

   // register reset values
   localparam logic [BYTE_W-1:0] START_CODE_RESET = 8'd35;
   localparam logic [BYTE_W-1:0] END_CODE_RESET   = 8'd13;
   localparam logic [LEN_W-1:0]  MAX_LEN_RESET    = 7'd34;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_CODE = 2'd0,
      CSR_END_CODE   = 2'd1,
      CSR_MAX_LEN    = 2'd2
   } csr_index_type;

   // item operations
   localparam logic OP_BYTE    = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   // readout sequencer states
   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_STREAM = 2'b10
   } state_type;

   // hand-off of a closed frame from the assembler to the readout
   typedef struct packed {
      logic              start;
      logic [ADDR_W-1:0] last_idx;
   } emit_type;

endpackage

>>> design/sfr_ram.sv
// sfr_ram: generic simple dual port ram with registered read
// no dependencies; holds the bytes of the frame being assembled

module sfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/sfr_ctrl.sv
// sfr_ctrl: configuration registers and frame assembly for each accepted item
// depends on sfr_pkg; writes the frame memory and hands closed frames to sfr_readout

module sfr_ctrl import sfr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_operation,
   input  logic [BYTE_W-1:0]    req_rx_byte,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_write_data,
   input  logic                 busy,
   output logic                 wr_en,
   output logic [ADDR_W-1:0]    wr_addr,
   output logic [BYTE_W-1:0]    wr_data,
   output emit_type             emit
);

   logic [BYTE_W-1:0] start_code_ff, start_code_in;
   logic [BYTE_W-1:0] end_code_ff, end_code_in;
   logic [LEN_W-1:0]  max_len_ff, max_len_in;
   logic [LEN_W-1:0]  fill_ff, fill_in;
   logic [BYTE_W-1:0] first_ff, first_in;
   logic [BYTE_W-1:0] prev_ff, prev_in;
   logic              held_ff, held_in;

   logic              accept;
   logic              byte_op;
   logic              rel_op;
   logic              is_start;
   logic [BYTE_W-1:0] first_new;
   logic [LEN_W-1:0]  fill_base;
   logic              bump;
   logic [LEN_W-1:0]  fill_next;
   logic [BYTE_W-1:0] prev_new;
   logic              last_end;
   logic [LEN_W-1:0]  limit;
   logic              overflow;

   assign req_ready = !busy;
   assign accept    = req_valid & req_ready;
   assign byte_op   = accept & (req_operation == OP_BYTE);
   assign rel_op    = accept & (req_operation == OP_RELEASE);

   // per-byte frame tracking; prev holds the byte just below the fill index
   always_comb begin
      is_start  = (req_rx_byte == start_code_ff);
      first_new = is_start ? start_code_ff : ((fill_ff == '0) ? req_rx_byte : first_ff);
      fill_base = is_start ? '0 : fill_ff;
      bump      = (first_new == start_code_ff);
      fill_next = fill_base + LEN_W'(bump);
      prev_new  = bump ? req_rx_byte : prev_ff;
      last_end  = (fill_next != '0) && (prev_new == end_code_ff);
      limit     = (max_len_ff > LEN_W'(LIMIT_CAP)) ? LEN_W'(LIMIT_CAP) : max_len_ff;
      overflow  = (fill_next > limit);
   end

   // memory write: a start byte always lands at entry zero
   assign wr_en   = byte_op & (is_start | (32'(fill_ff) < BUFFER_DEPTH));
   assign wr_addr = is_start ? '0 : ADDR_W'(fill_ff);
   assign wr_data = req_rx_byte;

   // next state of the assembler
   always_comb begin
      fill_in       = fill_ff;
      first_in      = first_ff;
      prev_in       = prev_ff;
      held_in       = held_ff;
      emit.start    = 1'b0;
      emit.last_idx = ADDR_W'(fill_next - 1'b1);
      if (byte_op) begin
         fill_in  = fill_next;
         first_in = first_new;
         prev_in  = prev_new;
         if (overflow) begin
            // frame too long: drop it and clear the hold
            fill_in  = '0;
            first_in = '0;
            held_in  = 1'b0;
         end else if (last_end) begin
            // frame closed: send it if nothing is held, otherwise discard
            fill_in  = '0;
            first_in = '0;
            if (!held_ff) begin
               emit.start = 1'b1;
               held_in    = 1'b1;
            end
         end
      end
      if (rel_op) begin
         held_in = 1'b0;
      end
   end

   // configuration register decode
   always_comb begin
      start_code_in = start_code_ff;
      end_code_in   = end_code_ff;
      max_len_in    = max_len_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_START_CODE: start_code_in = csr_write_data;
            CSR_END_CODE:   end_code_in   = csr_write_data;
            CSR_MAX_LEN:    max_len_in    = csr_write_data[LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_code_ff <= START_CODE_RESET;
         end_code_ff   <= END_CODE_RESET;
         max_len_ff    <= MAX_LEN_RESET;
         fill_ff       <= '0;
         first_ff      <= '0;
         held_ff       <= 1'b0;
      end else begin
         start_code_ff <= start_code_in;
         end_code_ff   <= end_code_in;
         max_len_ff    <= max_len_in;
         fill_ff       <= fill_in;
         first_ff      <= first_in;
         held_ff       <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_ff <= prev_in;
   end

`ifndef SYNTHESIS
   a_fill_capped: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= LIMIT_CAP)
      else $error("fill index beyond the frame limit cap");

   a_emit_holds: assert property (@(posedge clock) disable iff (reset)
      emit.start |=> held_ff)
      else $error("sent frame not held");

   a_release_clears: assert property (@(posedge clock) disable iff (reset)
      rel_op |=> !held_ff)
      else $error("release transfer left the hold set");
`endif

endmodule

>>> design/sfr_readout.sv
// sfr_readout: streams a closed frame out of the frame memory, one byte a cycle while rsp_ready is high
// depends on sfr_pkg; the memory read register serves as the output data register

module sfr_readout import sfr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  emit_type          emit,
   output logic              busy,
   output logic              rd_en,
   output logic [ADDR_W-1:0] rd_addr,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_frame_last
);

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] rd_idx_ff, rd_idx_in;
   logic [ADDR_W-1:0] last_idx_ff, last_idx_in;
   logic              valid_ff, valid_in;
   logic              last_ff, last_in;
   logic              issue;

   // while streaming, a read goes out whenever the output register is empty or being emptied
   assign issue   = (state_ff == ST_STREAM) & (!valid_ff | rsp_ready);
   assign rd_en   = issue;
   assign rd_addr = rd_idx_ff;
   assign busy    = (state_ff == ST_STREAM);

   // sequencer
   always_comb begin
      state_in    = state_ff;
      rd_idx_in   = rd_idx_ff;
      last_idx_in = last_idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (emit.start) begin
               state_in    = ST_STREAM;
               rd_idx_in   = '0;
               last_idx_in = emit.last_idx;
            end
         end
         ST_STREAM: begin
            if (issue) begin
               rd_idx_in = rd_idx_ff + 1'b1;
               if (rd_idx_ff == last_idx_ff) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register flags
   always_comb begin
      valid_in = issue ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);
      last_in  = issue ? (rd_idx_ff == last_idx_ff) : last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rd_idx_ff <= '0;
         valid_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_idx_ff <= rd_idx_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_idx_ff <= last_idx_in;
      last_ff     <= last_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_frame_last = last_ff;

`ifndef SYNTHESIS
   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      emit.start |-> (state_ff == ST_IDLE))
      else $error("frame handed over while streaming");

   a_last_ends_stream: assert property (@(posedge clock) disable iff (reset)
      (issue && (rd_idx_ff == last_idx_ff)) |=>
         ((state_ff == ST_IDLE) && rsp_valid && rsp_frame_last))
      else $error("final byte read without ending the stream");
`endif

endmodule

>>> design/serial_frame_receiver.sv
// Serial frame receiver. Each transfer on the req_ channel is one received byte or a release
// of the held frame. Bytes are gathered in a frame memory until the end code follows an opened
// frame; if no earlier frame is held, that frame of N bytes (start code first, end code flagged
// last) is then read out of the memory's single read port at one byte per cycle while rsp_ready
// is high, and no new item is taken while the frame streams out. The frame memory needs no
// clearing after reset.
// depends on sfr_pkg, sfr_ram, sfr_ctrl and sfr_readout

module serial_frame_receiver import sfr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_operation,
   input  logic [BYTE_W-1:0]    req_rx_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [BYTE_W-1:0]    rsp_frame_byte,
   output logic                 rsp_frame_last,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_write_data
);

   logic              busy;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [BYTE_W-1:0] wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   emit_type          emit;

   // frame assembly and configuration
   sfr_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_rx_byte      (req_rx_byte),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .busy             (busy),
      .wr_en            (wr_en),
      .wr_addr          (wr_addr),
      .wr_data          (wr_data),
      .emit             (emit)
   );

   // frame memory
   sfr_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (BUFFER_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rsp_frame_byte)
   );

   // frame readout
   sfr_readout u_readout (
      .clock          (clock),
      .reset          (reset),
      .emit           (emit),
      .busy           (busy),
      .rd_en          (rd_en),
      .rd_addr        (rd_addr),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule

>>> bench/tb_serial_frame_receiver.sv
// tb_serial_frame_receiver: self-checking bench for the serial frame receiver
// drives bytes and releases on req_, predicts every frame byte and checks rsp_ transfers
// depends on sfr_pkg and serial_frame_receiver

module tb_serial_frame_receiver;
   import sfr_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int ITEMS_TARGET = 36;

   typedef struct {
      logic [BYTE_W-1:0] data;
      logic              last;
   } frame_out_type;

   // clock, reset and block ports
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_operation = OP_BYTE;
   logic [BYTE_W-1:0]    req_rx_byte = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [BYTE_W-1:0]    rsp_frame_byte;
   logic                 rsp_frame_last;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [BYTE_W-1:0]    csr_write_data = '0;

   // shadow registers and assembler state of the predictor
   logic [BYTE_W-1:0] cfg_start   = START_CODE_RESET;
   logic [BYTE_W-1:0] cfg_end     = END_CODE_RESET;
   logic [LEN_W-1:0]  cfg_max_len = MAX_LEN_RESET;
   logic [BYTE_W-1:0] shadow_mem [BUFFER_DEPTH];
   int unsigned       shadow_fill = 0;
   logic [BYTE_W-1:0] shadow_head = '0;
   bit                shadow_hold = 1'b0;

   // frame bytes still owed by the block, oldest first
   frame_out_type pending_frame_bytes[$];

   // idling mix and bookkeeping
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int n_items        = 0;
   int n_releases     = 0;
   int n_results      = 0;
   int n_frames       = 0;
   int useful_items   = 0;
   int n_errors       = 0;
   int cycles         = 0;

   serial_frame_receiver dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_frame_byte   (rsp_frame_byte),
      .rsp_frame_last   (rsp_frame_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // clock generation, period 4
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic report_mismatch(input string what);
      n_errors++;
      $display("mismatch at cycle %0d: %s", cycles, what);
   endtask

   // compare every result transfer against the oldest owed byte
   always @(posedge clock) begin : check_results
      frame_out_type owed;
      if (!reset && rsp_valid && rsp_ready) begin
         n_results++;
         if (pending_frame_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %02h last %0b",
                                      rsp_frame_byte, rsp_frame_last));
         end else begin
            owed = pending_frame_bytes.pop_front();
            if (rsp_frame_byte !== owed.data)
               report_mismatch($sformatf("frame_byte %02h, predicted %02h",
                                         rsp_frame_byte, owed.data));
            if (rsp_frame_last !== owed.last)
               report_mismatch($sformatf("frame_last %0b, predicted %0b",
                                         rsp_frame_last, owed.last));
            if (owed.last)
               n_frames++;
         end
      end
   end

   // shadow store write; entry zero also tracks whether a frame has opened
   function automatic void put_byte(input int unsigned pos, input logic [BYTE_W-1:0] v);
      if (pos < BUFFER_DEPTH)
         shadow_mem[pos] = v;
      if (pos == 0)
         shadow_head = v;
   endfunction

   // an empty frame never counts as closed
   function automatic bit closed_on_end_code();
      return shadow_fill != 0 && shadow_fill <= BUFFER_DEPTH &&
             shadow_mem[shadow_fill-1] == cfg_end;
   endfunction

   // predict the frame bytes released by one accepted item
   function automatic void predict_item(input logic op, input logic [BYTE_W-1:0] b);
      int unsigned lim;
      int unsigned k;
      if (op == OP_RELEASE) begin
         shadow_hold = 1'b0;
         return;
      end
      lim = (cfg_max_len > LIMIT_CAP) ? LIMIT_CAP : cfg_max_len;
      put_byte(shadow_fill, b);
      if (b == cfg_start) begin
         shadow_fill = 0;
         put_byte(0, cfg_start);
      end
      if (shadow_head == cfg_start)
         shadow_fill++;
      if (shadow_fill > lim) begin
         // overlong frame is dropped and the hold cleared
         shadow_fill = 0;
         put_byte(0, '0);
         shadow_hold = 1'b0;
      end else if (closed_on_end_code() && !shadow_hold) begin
         for (k = 0; k < shadow_fill; k++)
            pending_frame_bytes.push_back('{data: shadow_mem[k], last: (k + 1 == shadow_fill)});
         shadow_fill = 0;
         put_byte(0, '0);
         shadow_hold = 1'b1;
      end
      // a frame closing while one is held is thrown away
      if (closed_on_end_code() && shadow_hold) begin
         shadow_fill = 0;
         put_byte(0, '0);
      end
   endfunction

   // one req_ transfer, with random sender gaps in front
   task automatic send_item(input logic op, input logic [BYTE_W-1:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_operation <= op;
      req_rx_byte   <= b;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      predict_item(op, b);
      n_items++;
      if (op == OP_RELEASE)
         n_releases++;
   endtask

   task automatic send_release();
      send_item(OP_RELEASE, 8'($urandom_range(255)));
      useful_items++;
   endtask

   // random byte that is neither frame code
   function automatic logic [BYTE_W-1:0] plain_byte();
      logic [BYTE_W-1:0] b;
      do
         b = 8'($urandom_range(255));
      while (b == cfg_start || b == cfg_end);
      return b;
   endfunction

   // start code, payload, optional end code
   task automatic send_frame(input int n_payload, input bit closed);
      int i;
      send_item(OP_BYTE, cfg_start);
      for (i = 0; i < n_payload; i++)
         send_item(OP_BYTE, ($urandom_range(19) == 0) ? 8'($urandom_range(255)) : plain_byte());
      if (closed)
         send_item(OP_BYTE, cfg_end);
      useful_items += n_payload + 1 + int'(closed);
   endtask

   // stop sending and wait for every owed byte
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_frame_bytes.size() != 0)
         @(posedge clock);
   endtask

   // block idle, safe for a register write
   task automatic settle();
      drain();
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [BYTE_W-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_START_CODE: cfg_start   = value;
         CSR_END_CODE:   cfg_end     = value;
         CSR_MAX_LEN:    cfg_max_len = value[LEN_W-1:0];
         default: ;
      endcase
   endtask

   // reset codes: noise, index zero, hold, discard, restart
   task automatic test_default_codes();
      send_item(OP_BYTE, 8'h00);
      send_item(OP_BYTE, 8'hFF);
      send_item(OP_BYTE, cfg_end);
      send_item(OP_RELEASE, 8'h00);
      send_item(OP_BYTE, cfg_start);
      send_item(OP_BYTE, 8'h00);
      send_item(OP_BYTE, 8'hFF);
      send_item(OP_BYTE, cfg_end);
      // closes while the previous frame is held
      send_item(OP_BYTE, cfg_start);
      send_item(OP_BYTE, 8'h41);
      send_item(OP_BYTE, cfg_end);
      send_item(OP_RELEASE, 8'hFF);
      // start code restarts a frame midway
      send_item(OP_BYTE, cfg_start);
      send_item(OP_BYTE, 8'h55);
      send_item(OP_BYTE, cfg_start);
      send_item(OP_BYTE, 8'hAA);
      send_item(OP_BYTE, cfg_end);
      send_item(OP_RELEASE, 8'h5A);
      send_item(OP_BYTE, cfg_start);
      send_item(OP_BYTE, cfg_end);
      send_item(OP_RELEASE, 8'hA5);
      useful_items += 21;
   endtask

   // code and length extremes
   task automatic test_register_corners();
      settle();
      // identical codes give a one-byte frame
      write_reg(CSR_START_CODE, 8'hFF);
      write_reg(CSR_END_CODE, 8'hFF);
      send_item(OP_BYTE, 8'hFF);
      send_release();
      send_item(OP_BYTE, 8'h00);
      settle();
      write_reg(CSR_START_CODE, 8'h00);
      send_frame(1, 1'b1);
      send_release();
      // zero limit drops at the start byte
      settle();
      write_reg(CSR_MAX_LEN, 8'd0);
      send_frame(0, 1'b1);
      settle();
      write_reg(CSR_MAX_LEN, 8'd1);
      send_frame(0, 1'b1);
      settle();
      write_reg(CSR_MAX_LEN, 8'd2);
      send_frame(0, 1'b1);
      send_release();
      send_frame(1, 1'b1);
      // oversize limit saturates to the store depth
      settle();
      write_reg(CSR_MAX_LEN, 8'd127);
      send_frame(LIMIT_CAP - 2, 1'b1);
      send_release();
      send_frame(LIMIT_CAP - 1, 1'b1);
      send_release();
      settle();
      write_reg(CSR_MAX_LEN, 8'd64);
      send_frame(LIMIT_CAP - 2, 1'b1);
      send_release();
      send_frame(LIMIT_CAP - 1, 1'b1);
      send_release();
   endtask

   // mostly well-formed frames with random content, plus noise and broken frames
   task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                      input logic [LEN_W-1:0] max_len);
      int goal;
      int pick;
      int lim;
      int n;
      int j;
      settle();
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      write_reg(CSR_START_CODE, 8'($urandom_range(255)));
      if ($urandom_range(7) == 0)
         write_reg(CSR_END_CODE, cfg_start);
      else
         write_reg(CSR_END_CODE, 8'($urandom_range(255)));
      write_reg(CSR_MAX_LEN, BYTE_W'(max_len));
      lim  = (cfg_max_len > LIMIT_CAP) ? LIMIT_CAP : cfg_max_len;
      goal = useful_items + ITEMS_TARGET;
      while (useful_items < goal) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            n = ($urandom_range(9) != 0) ? $urandom_range(0, (lim < 10) ? lim : 10)
                                         : $urandom_range(0, lim);
            send_frame(n, 1'b1);
            if ($urandom_range(4) != 0)
               send_release();
         end else if (pick < 65) begin
            send_release();
         end else if (pick < 75) begin
            // noise outside any frame
            for (j = 0; j < $urandom_range(1, 3); j++)
               send_item(OP_BYTE, 8'($urandom_range(255)));
         end else if (pick < 85) begin
            send_frame($urandom_range(0, 6), 1'b0);
         end else if (pick < 93) begin
            send_item(OP_BYTE, cfg_end);
            useful_items++;
         end else if (pick < 96) begin
            send_frame(lim + $urandom_range(0, 2), 1'b1);
            send_release();
         end else begin
            // hold off until the block has caught up
            drain();
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_default_codes();
      test_register_corners();
      test_random_traffic(0, 0, 7'($urandom_range(2, 12)));
      test_random_traffic(49, 0, 7'd64);
      test_random_traffic(0, 49, 7'd2);
      test_random_traffic(8, 8, 7'($urandom_range(3, 40)));
      drain();
      repeat (LIMIT_CAP + 8) @(posedge clock);
      $display("covered %0d items (%0d releases), %0d frame bytes in %0d frames",
               n_items, n_releases, n_results, n_frames);
      $display("code and length corners plus four idling mixes, %0d mismatches", n_errors);
      if (n_errors == 0 && pending_frame_bytes.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
